>>> rtl/frame_ring_drop_oldest_defines.svh
// Assertion helpers for the frame ring.
`ifndef FRAME_RING_DROP_OLDEST_DEFINES_SVH
`define FRAME_RING_DROP_OLDEST_DEFINES_SVH

`define FRD_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m failed");

`define FRD_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("never condition hit");

`endif

>>> rtl/frd_pkg.sv
package frd_pkg;

  localparam int RING_BYTES  = 2048;
  localparam int RING_FRAMES = 32;
  localparam int MAX_POP     = 64;

  localparam int BP_W = $clog2(RING_BYTES);
  localparam int BO_W = $clog2(RING_BYTES + 1);
  localparam int SP_W = $clog2(RING_FRAMES);
  localparam int FQ_W = $clog2(RING_FRAMES + 1);

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_BADLEN = 2'd1;
  localparam logic [1:0] ST_BUSY   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] frame_len;
    logic [7:0]  in_byte;
    logic [6:0]  pop_limit;
  } frd_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  push_status;
    logic [7:0]  out_byte;
    logic        last;
    logic [5:0]  frames_pending;
    logic [31:0] drop_count;
  } frd_out_t;

  // classified request handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] frame_len;
    logic [7:0]  in_byte;
    logic [6:0]  pop_limit;
  } frd_cmd_t;

endpackage

>>> rtl/frd_front.sv
module frd_front import frd_pkg::*; (
  input  logic     in_start,
  input  logic     q_full,
  input  frd_in_t  in_req,
  output logic     push,
  output frd_cmd_t cmd,
  output logic     busy
);
  assign busy = q_full;
  assign push = in_start && !q_full && in_req.op != OP_UNUSED;
  always_comb begin
    cmd.op        = in_req.op;
    cmd.frame_len = in_req.frame_len;
    cmd.in_byte   = in_req.in_byte;
    cmd.pop_limit = (in_req.pop_limit > 7'(MAX_POP)) ? 7'(MAX_POP) : in_req.pop_limit;
  end
endmodule

>>> rtl/frd_queue.sv
module frd_queue import frd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  frd_cmd_t din,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output frd_cmd_t dout
);
  frd_cmd_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  assign full  = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign dout  = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(pop);
    end
  end
endmodule

>>> rtl/frd_back.sv
module frd_back import frd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  frd_cmd_t cmd,
  output logic     q_pop,
  output logic     out_valid,
  output frd_out_t out_res,
  output logic     idle
);
  typedef enum logic [2:0] {S_IDLE, S_LEN, S_MAKE, S_POPRD, S_POP, S_EMRD, S_EM} state_t;
  state_t st_r;

  logic [7:0]  bmem [RING_BYTES];
  logic [11:0] lmem [RING_FRAMES];
  logic [7:0]  brd_r;
  logic [11:0] lrd_r;

  logic [BP_W-1:0] bwp_r, brp_r, erp_r;
  logic [BO_W-1:0] bocc_r;
  logic [SP_W-1:0] swp_r, srp_r;
  logic [FQ_W-1:0] fq_r;
  logic [31:0]     drops_r;
  logic [11:0]     oc_r, wrem_r, wlen_r;
  logic            wdisc_r;
  logic [11:0]     nlen_r;
  logic [6:0]      lim_r, cnt_r, ecnt_r;

  logic [11:0] left;
  logic [BO_W-1:0] free;
  always_comb begin
    left = (lrd_r > oc_r) ? lrd_r - oc_r : 12'd0;
    if (BO_W'(left) > bocc_r) left = 12'(bocc_r);
    free = BO_W'(RING_BYTES) - bocc_r;
  end

  assign idle  = st_r == S_IDLE;
  assign q_pop = idle && !q_empty;

  logic [BP_W-1:0] waddr;
  assign waddr = bwp_r + BP_W'(wlen_r - wrem_r);

  always_ff @(posedge clk) begin
    if (q_pop && cmd.op == OP_DATA && wrem_r != 0 && !wdisc_r) bmem[waddr] <= cmd.in_byte;
    if (q_pop && cmd.op == OP_DATA && wrem_r == 12'd1 && !wdisc_r) lmem[swp_r] <= wlen_r;
    brd_r <= bmem[erp_r];
    lrd_r <= lmem[srp_r];
  end

  function automatic logic [31:0] inc_sat(input logic [31:0] v);
    inc_sat = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      bwp_r <= '0; brp_r <= '0; bocc_r <= '0;
      swp_r <= '0; srp_r <= '0; fq_r <= '0;
      drops_r <= '0; oc_r <= '0; wrem_r <= '0; wlen_r <= '0; wdisc_r <= 1'b0;
      out_valid <= 1'b0;
      nlen_r <= '0; lim_r <= '0; cnt_r <= '0;
      erp_r <= '0; ecnt_r <= '0;
    end else begin
      out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            priority case (cmd.op)
              OP_START: begin
                wrem_r <= '0; wlen_r <= '0; wdisc_r <= 1'b0;
                if (cmd.frame_len == 0 || cmd.frame_len > 16'(RING_BYTES)) begin
                  out_valid <= 1'b1;
                  out_res <= '{KIND_STATUS, ST_BADLEN, 8'd0, 1'b1, 6'(fq_r), drops_r};
                end else begin
                  nlen_r <= cmd.frame_len[11:0];
                  st_r <= S_LEN;
                end
              end
              OP_DATA: begin
                if (wrem_r != 0) begin
                  wrem_r <= wrem_r - 12'd1;
                  if (wrem_r == 12'd1) begin
                    if (!wdisc_r) begin
                      swp_r <= swp_r + 1'b1;
                      fq_r <= fq_r + 1'b1;
                      bwp_r <= bwp_r + BP_W'(wlen_r);
                      bocc_r <= bocc_r + BO_W'(wlen_r);
                    end
                    wdisc_r <= 1'b0;
                    wlen_r <= '0;
                  end
                end
              end
              default: begin
                lim_r <= cmd.pop_limit;
                cnt_r <= '0;
                erp_r <= brp_r;
                ecnt_r <= '0;
                st_r <= S_POPRD;
              end
            endcase
          end
        end
        S_LEN: st_r <= S_MAKE;
        S_MAKE: begin
          if (free < BO_W'(nlen_r) || fq_r >= FQ_W'(RING_FRAMES)) begin
            if (fq_r == 0) begin
              out_valid <= 1'b1;
              out_res <= '{KIND_STATUS, ST_BADLEN, 8'd0, 1'b1, 6'(fq_r), drops_r};
              st_r <= S_IDLE;
            end else if (oc_r != 0) begin
              out_valid <= 1'b1;
              out_res <= '{KIND_STATUS, ST_BUSY, 8'd0, 1'b1, 6'(fq_r), inc_sat(drops_r)};
              drops_r <= inc_sat(drops_r);
              wrem_r <= nlen_r; wlen_r <= nlen_r; wdisc_r <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              srp_r <= srp_r + 1'b1;
              fq_r <= fq_r - 1'b1;
              brp_r <= brp_r + BP_W'(left);
              bocc_r <= bocc_r - BO_W'(left);
              oc_r <= '0;
              drops_r <= inc_sat(drops_r);
              st_r <= S_LEN;
            end
          end else begin
            out_valid <= 1'b1;
            out_res <= '{KIND_STATUS, ST_STORED, 8'd0, 1'b1, 6'(fq_r), drops_r};
            wrem_r <= nlen_r; wlen_r <= nlen_r;
            st_r <= S_IDLE;
          end
        end
        S_POPRD: begin
          if (fq_r == 0 || cnt_r >= lim_r) begin
            if (cnt_r == 0) begin
              out_valid <= 1'b1;
              out_res <= '{KIND_EMPTY, ST_STORED, 8'd0, 1'b1, 6'(fq_r), drops_r};
              st_r <= S_IDLE;
            end else st_r <= S_EMRD;
          end else st_r <= S_POP;
        end
        // walk the frames first so every byte result carries the final count
        S_POP: begin
          logic fin, endpop;
          logic [FQ_W-1:0] fqn;
          fin = (oc_r + 12'd1) >= lrd_r;
          fqn = fin ? fq_r - 1'b1 : fq_r;
          endpop = (fqn == 0) || (cnt_r + 7'd1 >= lim_r);
          brp_r <= brp_r + 1'b1;
          if (bocc_r != 0) bocc_r <= bocc_r - 1'b1;
          if (fin) begin
            srp_r <= srp_r + 1'b1;
            oc_r <= '0;
          end else oc_r <= oc_r + 12'd1;
          fq_r <= fqn;
          cnt_r <= cnt_r + 7'd1;
          st_r <= endpop ? S_EMRD : S_POPRD;
        end
        S_EMRD: st_r <= S_EM;
        S_EM: begin
          logic elast;
          elast = (ecnt_r + 7'd1) == cnt_r;
          out_valid <= 1'b1;
          out_res <= '{KIND_BYTE, ST_STORED, brd_r, elast, 6'(fq_r), drops_r};
          erp_r <= erp_r + 1'b1;
          ecnt_r <= ecnt_r + 7'd1;
          st_r <= elast ? S_IDLE : S_EMRD;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/frame_ring_drop_oldest.sv
// Frame start: status follows S_LEN and S_MAKE, both repeated per dropped frame; a bad
// length is answered from S_IDLE. Data byte: no result; drains one per cycle while idle.
// Pop: S_POPRD and S_POP walk the ring per byte, then S_EMRD and S_EM emit each byte;
// an empty pop answers from S_POPRD. 4-entry queue: one request per cycle unless busy.
// Reset: synchronous active-low rst_n clears pointers, counters and the queue.
// The receiver cannot stall: each result strobes out_valid for one cycle.
`include "frame_ring_drop_oldest_defines.svh"
module frame_ring_drop_oldest import frd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  frd_in_t  in_req,
  output logic     out_valid,
  output frd_out_t out_res
);
  logic q_full, q_empty, push, q_pop, idle;
  frd_cmd_t cmd_in, cmd_out;

  frd_front u_front (.in_start(start), .q_full, .in_req,
                     .push, .cmd(cmd_in), .busy);
  frd_queue u_queue (.clk, .rst_n, .push, .din(cmd_in), .full(q_full),
                     .pop(q_pop), .empty(q_empty), .dout(cmd_out));
  frd_back  u_back  (.clk, .rst_n, .q_empty, .cmd(cmd_out), .q_pop,
                     .out_valid, .out_res, .idle);

  `FRD_ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && q_empty)
  `FRD_ASSERT_NEVER(a_push_full, clk, rst_n, push && q_full)
  `FRD_ASSERT_NEVER(a_status_last, clk, rst_n,
    out_valid && out_res.kind == KIND_STATUS && !out_res.last)
endmodule

>>> sim/frame_ring_drop_oldest_tb.sv
module frame_ring_drop_oldest_tb;
  import frd_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  frd_in_t  in_req;
  logic     out_valid;
  frd_out_t out_res;

  frame_ring_drop_oldest dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  // ring shadow state
  logic [7:0]  ring_data [RING_BYTES];
  logic [11:0] slot_len [RING_FRAMES];
  int unsigned wr_pos, rd_pos, occupied, slot_wr, slot_rd, frames_q;
  int unsigned oldest_used, wr_left, wr_len;
  logic [31:0] drops;
  bit          wr_discard;

  frd_out_t expected_q[$];
  int       errors;
  bit       idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("** frame_ring_drop_oldest: FAILED **");
    $finish;
  end

  function automatic void count_drop();
    if (drops != 32'hFFFF_FFFF) drops = drops + 1;
  endfunction

  function automatic frd_out_t mk_res(logic [1:0] k, logic [1:0] st, logic [7:0] b,
                                      logic l);
    frd_out_t r;
    r.kind = k;
    r.push_status = st;
    r.out_byte = b;
    r.last = l;
    r.frames_pending = '0;
    r.drop_count = '0;
    return r;
  endfunction

  function automatic logic [1:0] open_frame(int unsigned len);
    int unsigned left;
    wr_left = 0;
    wr_len = 0;
    wr_discard = 1'b0;
    if (len == 0 || len > RING_BYTES) return ST_BADLEN;
    while ((RING_BYTES - occupied) < len || frames_q >= RING_FRAMES) begin
      if (frames_q == 0) return ST_BADLEN;
      if (oldest_used != 0) begin
        count_drop();
        wr_left = len;
        wr_len = len;
        wr_discard = 1'b1;
        return ST_BUSY;
      end
      left = slot_len[slot_rd];
      if (left > occupied) left = occupied;
      slot_rd = (slot_rd + 1) % RING_FRAMES;
      frames_q--;
      rd_pos = (rd_pos + left) % RING_BYTES;
      occupied -= left;
      count_drop();
    end
    wr_left = len;
    wr_len = len;
    return ST_STORED;
  endfunction

  function automatic void predict_ring(frd_in_t req);
    frd_out_t res[$];
    int unsigned lim;
    if (req.op == OP_START) begin
      res.push_back(mk_res(KIND_STATUS, open_frame(req.frame_len), 8'd0, 1'b1));
    end else if (req.op == OP_DATA) begin
      if (wr_left == 0) return;
      if (!wr_discard) ring_data[(wr_pos + wr_len - wr_left) % RING_BYTES] = req.in_byte;
      wr_left--;
      if (wr_left != 0) return;
      if (!wr_discard) begin
        slot_len[slot_wr] = wr_len;
        slot_wr = (slot_wr + 1) % RING_FRAMES;
        frames_q++;
        wr_pos = (wr_pos + wr_len) % RING_BYTES;
        occupied += wr_len;
      end
      wr_discard = 1'b0;
      wr_len = 0;
      return;
    end else if (req.op == OP_POP) begin
      lim = req.pop_limit > MAX_POP ? MAX_POP : req.pop_limit;
      while (frames_q > 0 && res.size() < lim) begin
        res.push_back(mk_res(KIND_BYTE, ST_STORED, ring_data[rd_pos], 1'b0));
        rd_pos = (rd_pos + 1) % RING_BYTES;
        if (occupied > 0) occupied--;
        oldest_used++;
        if (oldest_used >= slot_len[slot_rd]) begin
          slot_rd = (slot_rd + 1) % RING_FRAMES;
          frames_q--;
          oldest_used = 0;
        end
      end
      if (res.size() == 0) res.push_back(mk_res(KIND_EMPTY, ST_STORED, 8'd0, 1'b1));
      else res[res.size() - 1].last = 1'b1;
    end else begin
      return;
    end
    foreach (res[i]) begin
      res[i].frames_pending = frames_q[5:0];
      res[i].drop_count = drops;
      expected_q.push_back(res[i]);
    end
  endfunction

  always @(posedge clk) begin
    frd_out_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d", out_res.kind);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_res.kind !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, out_res.kind); errors++;
        end
        if (out_res.push_status !== e.push_status) begin
          $error("push_status exp %0d got %0d", e.push_status, out_res.push_status);
          errors++;
        end
        if (out_res.out_byte !== e.out_byte) begin
          $error("out_byte exp %0h got %0h", e.out_byte, out_res.out_byte); errors++;
        end
        if (out_res.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_res.last); errors++;
        end
        if (out_res.frames_pending !== e.frames_pending) begin
          $error("frames_pending exp %0d got %0d", e.frames_pending,
                 out_res.frames_pending);
          errors++;
        end
        if (out_res.drop_count !== e.drop_count) begin
          $error("drop_count exp %0d got %0d", e.drop_count, out_res.drop_count);
          errors++;
        end
      end
    end
  end

  task automatic send_request(logic [1:0] op, int unsigned len, logic [7:0] b,
                              logic [6:0] lim);
    frd_in_t req;
    req.op = op;
    req.frame_len = len[15:0];
    req.in_byte = b;
    req.pop_limit = lim;
    while (idle_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req <= req;
    @(posedge clk iff !busy);
    predict_ring(req);
  endtask

  task automatic push_frame(int unsigned len, int unsigned nbytes);
    send_request(OP_START, len, 8'd0, 7'd0);
    repeat (nbytes) send_request(OP_DATA, 0, 8'($urandom), 7'd0);
  endtask

  task automatic test_directed();
    send_request(OP_POP, 0, 8'd0, 7'd5);
    send_request(OP_DATA, 0, 8'hFF, 7'd0);
    send_request(OP_UNUSED, 16'hFFFF, 8'hFF, 7'h7F);
    send_request(OP_START, 0, 8'd0, 7'd0);
    send_request(OP_START, 16'hFFFF, 8'd0, 7'd0);
    send_request(OP_START, RING_BYTES + 1, 8'd0, 7'd0);
    push_frame(1, 1);
    send_request(OP_DATA, 0, 8'h00, 7'd0);
    push_frame(3, 2);
    push_frame(4, 4);
    send_request(OP_POP, 0, 8'd0, 7'd0);
    send_request(OP_POP, 0, 8'd0, 7'd2);
    send_request(OP_POP, 0, 8'd0, 7'h7F);
    push_frame(RING_BYTES, 0);
    send_request(OP_START, 5, 8'd0, 7'd0);
    send_request(OP_START, 5, 8'd0, 7'd0);
    send_request(OP_POP, 0, 8'd0, 7'd64);
  endtask

  task automatic test_overflow();
    // fill the slots, drop whole frames, then part-consume and force busy drops
    repeat (RING_FRAMES) push_frame(1, 1);
    push_frame(1, 1);
    send_request(OP_POP, 0, 8'd0, 7'd64);
    push_frame(3, 3);
    repeat (RING_FRAMES - 1) push_frame(1, 1);
    send_request(OP_POP, 0, 8'd0, 7'd1);
    push_frame(2, 2);
    push_frame(RING_BYTES, 2);
    send_request(OP_POP, 0, 8'd0, 7'd64);
    push_frame(2, 2);
    send_request(OP_START, RING_BYTES - 1, 8'd0, 7'd0);
    send_request(OP_POP, 0, 8'd0, 7'd5);
  endtask

  task automatic test_random(int n);
    int unsigned r, len;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        if ($urandom_range(19) == 0) begin
          len = $urandom_range(RING_BYTES);
          push_frame(len, $urandom_range(2));
        end else begin
          len = $urandom_range(1, 8);
          push_frame(len, ($urandom_range(9) == 0) ? $urandom_range(len) : len);
        end
      end else if (r < 90) begin
        send_request(OP_POP, 0, 8'd0, 7'($urandom_range(($urandom_range(7) == 0) ? 127 : 64)));
      end else begin
        send_request(2'($urandom), 16'($urandom), 8'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    errors = 0;
    idle_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    wr_pos = 0; rd_pos = 0; occupied = 0; slot_wr = 0; slot_rd = 0; frames_q = 0;
    oldest_used = 0; wr_left = 0; wr_len = 0; wr_discard = 1'b0; drops = '0;
    foreach (ring_data[i]) ring_data[i] = '0;
    foreach (slot_len[i]) slot_len[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    idle_on = 1'b0;
    test_random(15);
    idle_on = 1'b1;
    test_random(28);
    start <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** frame_ring_drop_oldest: PASSED **");
    end else begin
      $display("** frame_ring_drop_oldest: FAILED **");
    end
    $finish;
  end
endmodule
